@@ hw/rtl/icsp_pkg.sv @@
package icsp_pkg;

  // Frame queue and frame field sizing
  localparam int QUEUE_DEPTH = 16;
  localparam int MAX_BITS    = 40;
  localparam int DELAY_WIDTH = 12;

  localparam int QIDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int LEN_W  = $clog2(MAX_BITS + 1);
  localparam int BIDX_W = $clog2(MAX_BITS);
  localparam int BC_W   = $clog2(MAX_BITS + (1 << DELAY_WIDTH) + 1);

  // Port field widths
  localparam int LEN_IN_W   = 6;
  localparam int BITS_IN_W  = 40;
  localparam int DELAY_IN_W = 12;

  // Received word: bits WORD_FIRST .. WORD_FIRST+WORD_BITS-1 of the shift register
  localparam int RX_W       = 16;
  localparam int RX_IDX_W   = $clog2(RX_W);
  localparam int WORD_BITS  = 14;
  localparam int WORD_FIRST = 1;

  // Depth of the item queue between front and back
  localparam int ITEM_FIFO_DEPTH = 2;

  // Item opcodes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic                   dir_in;
    logic [LEN_W-1:0]       len;
    logic [MAX_BITS-1:0]    bits;
    logic [DELAY_WIDTH-1:0] delay;
    logic                   mclr_n;
  } frame_t;

  typedef struct packed {
    logic   tick;
    logic   dat_in;
    frame_t frame;
  } item_t;

  typedef struct packed {
    logic                 clk_pin;
    logic                 dat_out;
    logic                 dat_drive;
    logic                 mclr_n_pin;
    logic                 word_valid;
    logic [WORD_BITS-1:0] read_word;
    logic                 frame_advanced;
    logic                 list_done;
    logic                 push_accepted;
  } result_t;

endpackage

@@ hw/rtl/icsp_front.sv @@
module icsp_front (
  input  logic                            op_i,
  input  logic                            frame_dir_in_i,
  input  logic [icsp_pkg::LEN_IN_W-1:0]   frame_bits_len_i,
  input  logic [icsp_pkg::BITS_IN_W-1:0]  frame_bits_i,
  input  logic [icsp_pkg::DELAY_IN_W-1:0] frame_post_delay_i,
  input  logic                            frame_mclr_n_i,
  input  logic                            dat_in_i,
  output icsp_pkg::item_t                 item_o
);
  import icsp_pkg::*;

  logic len_over;

  // Saturate the length to the longest frame the sequencer handles
  assign len_over = (int'(frame_bits_len_i) > MAX_BITS);

  // Classify the word and pack the frame in its stored form
  always_comb begin
    item_o.tick         = (op_i == OP_TICK);
    item_o.dat_in       = dat_in_i;
    item_o.frame.dir_in = frame_dir_in_i;
    item_o.frame.len    = len_over ? LEN_W'(MAX_BITS) : LEN_W'(frame_bits_len_i);
    item_o.frame.bits   = MAX_BITS'(frame_bits_i);
    item_o.frame.delay  = DELAY_WIDTH'(frame_post_delay_i);
    item_o.frame.mclr_n = frame_mclr_n_i;
  end

endmodule

@@ hw/rtl/icsp_fifo.sv @@
module icsp_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  icsp_pkg::item_t push_item_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output icsp_pkg::item_t pop_item_o
);
  import icsp_pkg::*;

  localparam int PTR_W  = (ITEM_FIFO_DEPTH > 1) ? $clog2(ITEM_FIFO_DEPTH) : 1;
  localparam int FCNT_W = $clog2(ITEM_FIFO_DEPTH + 1);

  item_t             mem_q [ITEM_FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign push_ready_o = (cnt_q != FCNT_W'(ITEM_FIFO_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  // Advance pointers with wrap and track fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(ITEM_FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(ITEM_FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store incoming words
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

@@ hw/rtl/icsp_back.sv @@
module icsp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              item_valid_i,
  output logic              item_ready_o,
  input  icsp_pkg::item_t   item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output icsp_pkg::result_t result_o
);
  import icsp_pkg::*;

  localparam int SUM_W = QIDX_W + 1;

  // Frame store; cur_q mirrors the entry at the head
  frame_t            mem_q [QUEUE_DEPTH];
  frame_t            cur_q, cur_d;
  logic [QIDX_W-1:0] head_q, head_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [BC_W-1:0]   bc_q, bc_d;
  logic              clk_q, clk_d;
  logic              dat_q, dat_d;
  logic              drv_q, drv_d;
  logic              mclr_q, mclr_d;
  logic [RX_W-1:0]   shift_q, shift_d;
  logic              emit_q, emit_d;
  logic              out_valid_q, out_valid_d;
  result_t           res_q, res_d;

  logic              take;
  logic              wr_en;
  logic [QIDX_W-1:0] wr_idx;
  logic [QIDX_W-1:0] next_idx;
  logic [SUM_W-1:0]  tail_sum;
  frame_t            next_frame;
  logic [BC_W-1:0]   total;
  logic [MAX_BITS-1:0] bits_shr;

  assign item_ready_o = !out_valid_q || out_ready_i;
  assign take         = item_valid_i && item_ready_o;
  assign out_valid_o  = out_valid_q;
  assign result_o     = res_q;

  // Queue addressing with wrap at any depth
  assign next_idx   = (head_q == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign tail_sum   = SUM_W'(head_q) + SUM_W'(count_q);
  assign wr_idx     = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
                      QIDX_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : QIDX_W'(tail_sum);
  assign next_frame = mem_q[next_idx];
  assign total      = BC_W'(cur_q.len) + BC_W'(cur_q.delay);
  assign bits_shr   = cur_q.bits >> bc_q[BIDX_W-1:0];

  // Sequence one word: queue a frame or step the current one
  always_comb begin
    cur_d   = cur_q;
    head_d  = head_q;
    count_d = count_q;
    bc_d    = bc_q;
    clk_d   = clk_q;
    dat_d   = dat_q;
    drv_d   = drv_q;
    mclr_d  = mclr_q;
    shift_d = shift_q;
    emit_d  = emit_q;
    wr_en   = 1'b0;
    res_d   = res_q;

    if (take) begin
      res_d.word_valid     = 1'b0;
      res_d.read_word      = '0;
      res_d.frame_advanced = 1'b0;
      res_d.list_done      = 1'b0;
      res_d.push_accepted  = 1'b0;

      if (!item_i.tick) begin
        // Queue the frame unless full; an empty queue applies it at once
        if (count_q != CNT_W'(QUEUE_DEPTH)) begin
          wr_en               = 1'b1;
          count_d             = count_q + 1'b1;
          res_d.push_accepted = 1'b1;
          if (count_q == '0) begin
            cur_d  = item_i.frame;
            drv_d  = !item_i.frame.dir_in;
            mclr_d = item_i.frame.mclr_n;
          end
        end
      end else if (count_q != '0) begin
        // Bit phase: falling edge samples and counts, rising edge drives
        if (bc_q < BC_W'(cur_q.len)) begin
          if (clk_q) begin
            clk_d = 1'b0;
            if (cur_q.dir_in && (bc_q < BC_W'(RX_W)) && item_i.dat_in) begin
              shift_d = shift_q | (RX_W'(1) << bc_q[RX_IDX_W-1:0]);
            end
            bc_d = bc_q + 1'b1;
          end else begin
            if (!cur_q.dir_in) begin
              dat_d = bits_shr[0];
            end
            clk_d = 1'b1;
          end
        end else if (bc_q < total) begin
          // Post-delay phase
          bc_d = bc_q + 1'b1;
        end

        // Hand out the received word once all bits are in
        if (cur_q.dir_in && (bc_d >= BC_W'(cur_q.len)) && !emit_q) begin
          res_d.word_valid = 1'b1;
          res_d.read_word  = shift_d[WORD_FIRST +: WORD_BITS];
          emit_d           = 1'b1;
        end

        // Retire the frame and load the next one
        if ((bc_d >= total) && (!cur_q.dir_in || emit_d)) begin
          res_d.frame_advanced = 1'b1;
          head_d  = next_idx;
          count_d = count_q - 1'b1;
          bc_d    = '0;
          shift_d = '0;
          emit_d  = 1'b0;
          if (count_q == CNT_W'(1)) begin
            res_d.list_done = 1'b1;
          end else begin
            cur_d  = next_frame;
            drv_d  = !next_frame.dir_in;
            mclr_d = next_frame.mclr_n;
          end
        end
      end

      res_d.clk_pin    = clk_d;
      res_d.dat_out    = dat_d;
      res_d.dat_drive  = drv_d;
      res_d.mclr_n_pin = mclr_d;
    end
  end

  // Hold the result until taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (take) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= '0;
      bc_q        <= '0;
      clk_q       <= 1'b0;
      dat_q       <= 1'b0;
      drv_q       <= 1'b1;
      mclr_q      <= 1'b0;
      shift_q     <= '0;
      emit_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      count_q     <= count_d;
      bc_q        <= bc_d;
      clk_q       <= clk_d;
      dat_q       <= dat_d;
      drv_q       <= drv_d;
      mclr_q      <= mclr_d;
      shift_q     <= shift_d;
      emit_q      <= emit_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    res_q <= res_d;
    if (wr_en) begin
      mem_q[wr_idx] <= item_i.frame;
    end
  end

endmodule

@@ hw/rtl/icsp_frame_bit_sequencer.sv @@
// Each word passes through the item queue and then the back sequencer's output register before its result is valid.
// Throughput: one word per cycle while each result is taken; the back sequencer settles each word as it is accepted.
// A two-entry item queue separates intake from sequencing, plus one output register.
// Reset: frame queue empty, clock and data low, data driven, reset pin low, no result.
// Frame store contents are undefined after reset and are read only once written.
module icsp_frame_bit_sequencer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            op_i,
  input  logic                            frame_dir_in_i,
  input  logic [icsp_pkg::LEN_IN_W-1:0]   frame_bits_len_i,
  input  logic [icsp_pkg::BITS_IN_W-1:0]  frame_bits_i,
  input  logic [icsp_pkg::DELAY_IN_W-1:0] frame_post_delay_i,
  input  logic                            frame_mclr_n_i,
  input  logic                            dat_in_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            clk_pin_o,
  output logic                            dat_out_o,
  output logic                            dat_drive_o,
  output logic                            mclr_n_pin_o,
  output logic                            word_valid_o,
  output logic [icsp_pkg::WORD_BITS-1:0]  read_word_o,
  output logic                            frame_advanced_o,
  output logic                            list_done_o,
  output logic                            push_accepted_o
);
  import icsp_pkg::*;

  item_t   front_item;
  item_t   back_item;
  logic    back_valid;
  logic    back_ready;
  result_t result;

  icsp_front u_front (
    .op_i               (op_i),
    .frame_dir_in_i     (frame_dir_in_i),
    .frame_bits_len_i   (frame_bits_len_i),
    .frame_bits_i       (frame_bits_i),
    .frame_post_delay_i (frame_post_delay_i),
    .frame_mclr_n_i     (frame_mclr_n_i),
    .dat_in_i           (dat_in_i),
    .item_o             (front_item)
  );

  icsp_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_ready_o (in_ready_o),
    .push_item_i  (front_item),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready),
    .pop_item_o   (back_item)
  );

  icsp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (back_valid),
    .item_ready_o (back_ready),
    .item_i       (back_item),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .result_o     (result)
  );

  assign clk_pin_o        = result.clk_pin;
  assign dat_out_o        = result.dat_out;
  assign dat_drive_o      = result.dat_drive;
  assign mclr_n_pin_o     = result.mclr_n_pin;
  assign word_valid_o     = result.word_valid;
  assign read_word_o      = result.read_word;
  assign frame_advanced_o = result.frame_advanced;
  assign list_done_o      = result.list_done;
  assign push_accepted_o  = result.push_accepted;

endmodule

@@ tb/sv/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import icsp_pkg::*;

  localparam int unsigned RAND_WORDS  = 1950;
  localparam int unsigned PUSH_WORDS  = 1400;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned IDLE_PCT    = 11;
  localparam int unsigned TAIL_CYCLES = 8;
  localparam int unsigned PRINT_CAP   = 50;

  // One input word plus an optional hand-typed expectation
  typedef struct {
    logic                  op;
    logic                  dir;
    logic [LEN_IN_W-1:0]   len;
    logic [BITS_IN_W-1:0]  bits;
    logic [DELAY_IN_W-1:0] dly;
    logic                  mclr;
    logic                  din;
    bit                    typed;
    result_t               want;
  } step_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  op = OP_TICK;
  logic                  frame_dir = 1'b0;
  logic [LEN_IN_W-1:0]   frame_len = '0;
  logic [BITS_IN_W-1:0]  frame_bits = '0;
  logic [DELAY_IN_W-1:0] frame_dly = '0;
  logic                  frame_mclr = 1'b0;
  logic                  dat_in = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  clk_pin;
  logic                  dat_out;
  logic                  dat_drive;
  logic                  mclr_n_pin;
  logic                  word_valid;
  logic [WORD_BITS-1:0]  read_word;
  logic                  frame_advanced;
  logic                  list_done;
  logic                  push_accepted;

  int unsigned cycles = 0;
  int unsigned mismatches = 0;
  logic        steady;

  result_t   expected_pins_q[$];
  step_row_t directed_rows[$];

  // Shadow of the sequencer state
  frame_t      frame_store[QUEUE_DEPTH];
  int unsigned q_count = 0;
  int unsigned q_head = 0;
  int unsigned bit_cnt = 0;
  logic        clk_lvl = 1'b0;
  logic        dat_lvl = 1'b0;
  logic        drv_en = 1'b1;
  logic        rst_lvl = 1'b0;
  logic [15:0] rx_shift = '0;
  logic        word_done = 1'b0;

  icsp_frame_bit_sequencer i_dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .op_i               (op),
    .frame_dir_in_i     (frame_dir),
    .frame_bits_len_i   (frame_len),
    .frame_bits_i       (frame_bits),
    .frame_post_delay_i (frame_dly),
    .frame_mclr_n_i     (frame_mclr),
    .dat_in_i           (dat_in),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .clk_pin_o          (clk_pin),
    .dat_out_o          (dat_out),
    .dat_drive_o        (dat_drive),
    .mclr_n_pin_o       (mclr_n_pin),
    .word_valid_o       (word_valid),
    .read_word_o        (read_word),
    .frame_advanced_o   (frame_advanced),
    .list_done_o        (list_done),
    .push_accepted_o    (push_accepted)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Disable random idling on both sides inside this window
  assign steady = (cycles >= 1500) && (cycles < 3500);

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[icsp_frame_bit_sequencer] ERROR");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    if (mismatches < PRINT_CAP) begin
      $display("mismatch %s: got %0h, want %0h at cycle %0d", what, got, want, cycles);
    end
    mismatches++;
  endtask

  function automatic result_t pins_of(input logic c, input logic d, input logic drv,
                                      input logic m, input logic wv,
                                      input logic [WORD_BITS-1:0] w, input logic adv,
                                      input logic done, input logic acc);
    result_t r;
    r.clk_pin        = c;
    r.dat_out        = d;
    r.dat_drive      = drv;
    r.mclr_n_pin     = m;
    r.word_valid     = wv;
    r.read_word      = w;
    r.frame_advanced = adv;
    r.list_done      = done;
    r.push_accepted  = acc;
    return r;
  endfunction

  function automatic step_row_t tick_row(input logic din, input bit typed, input result_t want);
    step_row_t w;
    w       = '{default: '0};
    w.op    = OP_TICK;
    w.din   = din;
    w.typed = typed;
    w.want  = want;
    return w;
  endfunction

  function automatic step_row_t push_row(input logic dir, input logic [LEN_IN_W-1:0] len,
                                         input logic [BITS_IN_W-1:0] bits,
                                         input logic [DELAY_IN_W-1:0] dly, input logic mclr,
                                         input bit typed, input result_t want);
    step_row_t w;
    w       = '{default: '0};
    w.op    = OP_PUSH;
    w.dir   = dir;
    w.len   = len;
    w.bits  = bits;
    w.dly   = dly;
    w.mclr  = mclr;
    w.typed = typed;
    w.want  = want;
    return w;
  endfunction

  // Take direction and reset level from the head frame
  function automatic void load_head_pins();
    drv_en  = ~frame_store[q_head].dir_in;
    rst_lvl = frame_store[q_head].mclr_n;
  endfunction

  // Advance the shadow sequencer by one word and return the pins and flags it yields
  function automatic result_t link_step(input step_row_t w);
    result_t     r;
    frame_t      f;
    int unsigned ln;
    int unsigned total;
    int unsigned slot;
    r = '0;
    if (w.op == OP_PUSH) begin
      if (q_count < QUEUE_DEPTH) begin
        slot = (q_head + q_count) % QUEUE_DEPTH;
        ln = (w.len > MAX_BITS) ? MAX_BITS : w.len;
        frame_store[slot].dir_in = w.dir;
        frame_store[slot].len    = ln[LEN_W-1:0];
        frame_store[slot].bits   = w.bits;
        frame_store[slot].delay  = w.dly[DELAY_WIDTH-1:0];
        frame_store[slot].mclr_n = w.mclr;
        q_count++;
        r.push_accepted = 1'b1;
        if (q_count == 1) begin
          load_head_pins();
        end
      end
    end else if (q_count > 0) begin
      f = frame_store[q_head];
      ln = f.len;
      total = ln + f.delay;
      // Clock phase while bits remain, then count out the post delay
      if (bit_cnt < ln) begin
        if (clk_lvl) begin
          clk_lvl = 1'b0;
          if (f.dir_in && bit_cnt < 16 && w.din) begin
            rx_shift[bit_cnt] = 1'b1;
          end
          bit_cnt++;
        end else begin
          if (!f.dir_in) begin
            dat_lvl = f.bits[bit_cnt];
          end
          clk_lvl = 1'b1;
        end
      end else if (bit_cnt < total) begin
        bit_cnt++;
      end
      if (f.dir_in && bit_cnt >= ln && !word_done) begin
        r.word_valid = 1'b1;
        r.read_word  = rx_shift[WORD_FIRST +: WORD_BITS];
        word_done    = 1'b1;
      end
      // Retire the frame and move to the next one
      if (bit_cnt >= total && (!f.dir_in || word_done)) begin
        r.frame_advanced = 1'b1;
        q_head    = (q_head + 1) % QUEUE_DEPTH;
        q_count--;
        bit_cnt   = 0;
        rx_shift  = '0;
        word_done = 1'b0;
        if (q_count == 0) begin
          r.list_done = 1'b1;
        end else begin
          load_head_pins();
        end
      end
    end
    r.clk_pin    = clk_lvl;
    r.dat_out    = dat_lvl;
    r.dat_drive  = drv_en;
    r.mclr_n_pin = rst_lvl;
    return r;
  endfunction

  // Hold the word until it is accepted, then queue its expected pins
  task automatic feed_word(input step_row_t w);
    result_t p;
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    op         <= w.op;
    frame_dir  <= w.dir;
    frame_len  <= w.len;
    frame_bits <= w.bits;
    frame_dly  <= w.dly;
    frame_mclr <= w.mclr;
    dat_in     <= w.din;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    p = link_step(w);
    expected_pins_q.push_back(w.typed ? w.want : p);
  endtask

  // Random backpressure on the result side
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_pins_q.size() == 0) begin
        flag_mismatch("result with nothing pending", 1, 0);
      end else begin
        want = expected_pins_q.pop_front();
        if (clk_pin !== want.clk_pin) flag_mismatch("clk_pin", clk_pin, want.clk_pin);
        if (dat_out !== want.dat_out) flag_mismatch("dat_out", dat_out, want.dat_out);
        if (dat_drive !== want.dat_drive) begin
          flag_mismatch("dat_drive", dat_drive, want.dat_drive);
        end
        if (mclr_n_pin !== want.mclr_n_pin) begin
          flag_mismatch("mclr_n_pin", mclr_n_pin, want.mclr_n_pin);
        end
        if (word_valid !== want.word_valid) begin
          flag_mismatch("word_valid", word_valid, want.word_valid);
        end
        if (read_word !== want.read_word) begin
          flag_mismatch("read_word", read_word, want.read_word);
        end
        if (frame_advanced !== want.frame_advanced) begin
          flag_mismatch("frame_advanced", frame_advanced, want.frame_advanced);
        end
        if (list_done !== want.list_done) begin
          flag_mismatch("list_done", list_done, want.list_done);
        end
        if (push_accepted !== want.push_accepted) begin
          flag_mismatch("push_accepted", push_accepted, want.push_accepted);
        end
      end
    end
  end

  initial begin : stimulus
    step_row_t   w;
    logic [63:0] r64;
    int unsigned sent_rand;
    int unsigned burst_left;
    int unsigned roll;
    bit          long_done;
    sent_rand  = 0;
    burst_left = 0;
    long_done  = 1'b0;

    // Tick on an empty queue right after reset
    directed_rows.push_back(tick_row(1'b1, 1'b1, pins_of(0, 0, 1, 0, 0, 0, 0, 0, 0)));
    // Push into an empty queue: reset level applies at once
    directed_rows.push_back(push_row(1'b0, 6'd1, '1, '0, 1'b1, 1'b1,
                                     pins_of(0, 0, 1, 1, 0, 0, 0, 0, 1)));
    directed_rows.push_back(tick_row(1'b0, 1'b1, pins_of(1, 1, 1, 1, 0, 0, 0, 0, 0)));
    // Last bit ends the list
    directed_rows.push_back(tick_row(1'b0, 1'b1, pins_of(0, 1, 1, 1, 0, 0, 1, 1, 0)));
    // Zero-length receive frame, then a short receive frame behind it
    directed_rows.push_back(push_row(1'b1, 6'd0, '0, '0, 1'b0, 1'b1,
                                     pins_of(0, 1, 0, 0, 0, 0, 0, 0, 1)));
    directed_rows.push_back(push_row(1'b1, 6'd3, '1, 12'd2, 1'b1, 1'b1,
                                     pins_of(0, 1, 0, 0, 0, 0, 0, 0, 1)));
    directed_rows.push_back(tick_row(1'b1, 1'b1, pins_of(0, 1, 0, 1, 1, 0, 1, 0, 0)));
    repeat (8) directed_rows.push_back(tick_row(1'b1, 1'b0, '0));
    // Send frame, with a push landing while it is active
    directed_rows.push_back(push_row(1'b0, 6'd2, 40'hFF_FFFF_FFFE, '0, 1'b0, 1'b1,
                                     pins_of(0, 1, 1, 0, 0, 0, 0, 0, 1)));
    directed_rows.push_back(tick_row(1'b0, 1'b0, '0));
    directed_rows.push_back(tick_row(1'b1, 1'b0, '0));
    directed_rows.push_back(push_row(1'b1, 6'd0, '0, '0, 1'b1, 1'b0, '0));
    repeat (3) directed_rows.push_back(tick_row(1'b0, 1'b0, '0));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      feed_word(directed_rows[i]);
    end

    // Random frame lists with random content, then ticks only so the queue drains
    while (sent_rand < RAND_WORDS || q_count != 0) begin
      w     = '{default: '0};
      w.din = 1'($urandom_range(1));
      roll  = $urandom_range(99);
      if (sent_rand < PUSH_WORDS && burst_left == 0 && q_count == 0 &&
          $urandom_range(39) == 0) begin
        burst_left = QUEUE_DEPTH + 2;
      end
      if (sent_rand >= PUSH_WORDS) begin
        w.op = OP_TICK;
      end else if (burst_left != 0) begin
        w.op = OP_PUSH;
      end else if (q_count == 0) begin
        w.op = (roll < 85) ? OP_PUSH : OP_TICK;
      end else begin
        w.op = (roll < 7) ? OP_PUSH : OP_TICK;
      end
      if (w.op == OP_PUSH) begin
        r64    = {$urandom, $urandom};
        w.bits = r64[BITS_IN_W-1:0];
        w.dir  = 1'($urandom_range(1));
        w.mclr = 1'($urandom_range(1));
        roll   = $urandom_range(99);
        if (burst_left != 0) begin
          // Fill the queue past its depth with short frames
          w.len = LEN_IN_W'($urandom_range(2));
          w.dly = DELAY_IN_W'($urandom_range(1));
          burst_left--;
        end else if (!long_done && sent_rand > 400 && q_count == 0) begin
          // Oversized length and the longest post delay, once
          w.dir = 1'b0;
          w.len = '1;
          w.dly = '1;
          long_done = 1'b1;
        end else begin
          if (roll < 55) w.len = LEN_IN_W'($urandom_range(13));
          else if (roll < 80) w.len = LEN_IN_W'($urandom_range(16, 14));
          else if (roll < 95) w.len = LEN_IN_W'($urandom_range(MAX_BITS, 17));
          else w.len = LEN_IN_W'($urandom_range(63, MAX_BITS + 1));
          w.dly = ($urandom_range(9) == 0) ? DELAY_IN_W'($urandom_range(40, 5))
                                           : DELAY_IN_W'($urandom_range(4));
        end
      end
      feed_word(w);
      sent_rand++;
    end
    in_valid <= 1'b0;

    while (expected_pins_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[icsp_frame_bit_sequencer] OK");
    end else begin
      $display("[icsp_frame_bit_sequencer] ERROR");
    end
    $finish;
  end

endmodule
